@@ src/hdkt_pkg.sv @@
// Package for the distinct-key tracker: word types, status codes, sizes, hash mix constants.
// No dependencies.
package hdkt_pkg;
   localparam int TABLE_SLOTS_DEF = 1024;
   localparam int MAX_ITEMS_DEF   = 1048576;
   localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef struct packed {
      logic        cmd;
      logic [63:0] key_word;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [20:0] first_index;
      logic [20:0] occurrences;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic mul_sum;
      logic probe_start;
      logic probe_next;
      logic read_slot;
      logic write_new;
      logic write_dup;
      logic clear_step;
      logic clear_start;
   } cmd_type;

   typedef struct packed {
      logic slot_valid;
      logic key_match;
      logic probes_done;
      logic clear_done;
   } sts_type;
endpackage

@@ src/hash_distinct_key_tracker.sv @@
// Distinct-key tracker: an open-addressing hash table with triangular probing over key words.
// An insert runs two 64-bit mix multiplies, each built from 32-bit partial products that are
// registered in a multiply state and then summed in a sum state, then one registered slot read
// and one compare per probe; a clear is a sweep of the valid memory at one entry per cycle,
// and after reset the same sweep runs before the first word is taken.
// TABLE_SLOTS must be a power of two.
// Depends on hdkt_pkg, hdkt_controller, hdkt_datapath.
module hash_distinct_key_tracker #(
   parameter int TABLE_SLOTS = hdkt_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_ITEMS   = hdkt_pkg::MAX_ITEMS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hdkt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hdkt_pkg::rsp_word_type rsp_word
);
   import hdkt_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [20:0] item, rd_first, rd_count;

   hdkt_controller #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word,
      .cmd, .sts, .item_out(item), .rd_first, .rd_count
   );

   hdkt_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
      .clock, .reset, .key_in(req_word.key_word), .cmd, .item_in(item),
      .sts, .rd_first, .rd_count
   );
endmodule

@@ src/hdkt_datapath.sv @@
// Datapath of the distinct-key tracker: hash mix, probe address, slot memories, valid sweep.
// Depends on hdkt_pkg.
module hdkt_datapath #(
   parameter int TABLE_SLOTS = hdkt_pkg::TABLE_SLOTS_DEF,
   parameter int AW          = $clog2(TABLE_SLOTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [63:0]           key_in,
   input  hdkt_pkg::cmd_type     cmd,
   input  logic [20:0]           item_in,
   output hdkt_pkg::sts_type     sts,
   output logic [20:0]           rd_first,
   output logic [20:0]           rd_count
);
   import hdkt_pkg::*;

   logic [63:0]   key_ff, z_ff, z_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW:0]   k_ff, k_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [63:0]   z1, z2, z3;
   logic [63:0]   mul_a, mul_c;
   logic [31:0]   a_lo, a_hi, c_lo, c_hi;
   logic [63:0]   pll_ff, pll_in;
   logic [31:0]   cross_ff, cross_in;

   logic [63:0]   mem_key   [TABLE_SLOTS];
   logic [20:0]   mem_first [TABLE_SLOTS];
   logic [20:0]   mem_count [TABLE_SLOTS];
   logic          mem_valid [TABLE_SLOTS];
   logic [63:0]   rd_key_ff;
   logic          rd_valid_ff;
   logic [20:0]   rd_first_ff, rd_count_ff;

   assign z1 = z_ff ^ (z_ff >> 30);
   assign z2 = z_ff ^ (z_ff >> 27);
   assign z3 = z_ff ^ (z_ff >> 31);

   assign mul_a = cmd.mul2 ? z2 : z1;
   assign mul_c = cmd.mul2 ? MIX_C2 : MIX_C1;
   assign a_lo  = mul_a[31:0];
   assign a_hi  = mul_a[63:32];
   assign c_lo  = mul_c[31:0];
   assign c_hi  = mul_c[63:32];

   always_comb begin
      pll_in   = pll_ff;
      cross_in = cross_ff;
      if (cmd.mul1 || cmd.mul2) begin
         pll_in   = 64'(a_lo) * 64'(c_lo);
         cross_in = a_lo * c_hi + a_hi * c_lo;
      end
      z_in = z_ff;
      if (cmd.load) z_in = key_in;
      else if (cmd.mul_sum) z_in = pll_ff + {cross_ff, 32'd0};
      addr_in = addr_ff;
      k_in    = k_ff;
      if (cmd.probe_start) begin
         addr_in = AW'(z3[31:0] ^ z3[63:32]);
         k_in    = '0;
      end else if (cmd.probe_next) begin
         addr_in = addr_ff + AW'(k_ff) + AW'(1);
         k_in    = k_ff + 1'b1;
      end
      clr_in = cmd.clear_start ? '0 : (cmd.clear_step ? clr_ff + 1'b1 : clr_ff);
   end

   always_ff @(posedge clock) begin
      z_ff     <= z_in;
      addr_ff  <= addr_in;
      k_ff     <= k_in;
      pll_ff   <= pll_in;
      cross_ff <= cross_in;
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
      if (cmd.load) key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem_valid[clr_ff] <= 1'b0;
      else if (cmd.write_new) mem_valid[addr_ff] <= 1'b1;
      if (cmd.write_new) begin
         mem_key[addr_ff]   <= key_ff;
         mem_first[addr_ff] <= item_in;
         mem_count[addr_ff] <= 21'd1;
      end else if (cmd.write_dup) begin
         mem_count[addr_ff] <= rd_count_ff + 21'd1;
      end
      if (cmd.read_slot) begin
         rd_valid_ff <= mem_valid[addr_ff];
         rd_key_ff   <= mem_key[addr_ff];
         rd_first_ff <= mem_first[addr_ff];
         rd_count_ff <= mem_count[addr_ff];
      end
   end

   assign sts.slot_valid  = rd_valid_ff;
   assign sts.key_match   = (rd_key_ff == key_ff);
   assign sts.probes_done = (k_ff == (AW+1)'(TABLE_SLOTS - 1));
   assign sts.clear_done  = (clr_ff == AW'(TABLE_SLOTS - 1));
   assign rd_first = rd_first_ff;
   assign rd_count = rd_count_ff;
endmodule

@@ src/hdkt_controller.sv @@
// Controller of the distinct-key tracker: sequencing, item counter, response register.
// Depends on hdkt_pkg.
module hdkt_controller #(
   parameter int MAX_ITEMS = hdkt_pkg::MAX_ITEMS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hdkt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hdkt_pkg::rsp_word_type rsp_word,
   output hdkt_pkg::cmd_type      cmd,
   input  hdkt_pkg::sts_type      sts,
   output logic [20:0]            item_out,
   input  logic [20:0]            rd_first,
   input  logic [20:0]            rd_count
);
   import hdkt_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b00_0000_0001,
      S_IDLE  = 10'b00_0000_0010,
      S_MUL1  = 10'b00_0000_0100,
      S_SUM1  = 10'b00_0000_1000,
      S_MUL2  = 10'b00_0001_0000,
      S_SUM2  = 10'b00_0010_0000,
      S_HASH  = 10'b00_0100_0000,
      S_READ  = 10'b00_1000_0000,
      S_CHECK = 10'b01_0000_0000,
      S_WIPE  = 10'b10_0000_0000
   } state_type;

   state_type    state_ff, state_in;
   logic [24:0]  item_ff, item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;
   logic         accept;

   assign req_stall = !(state_ff == S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_word.cmd) begin
                  item_in          = '0;
                  cmd.clear_start  = 1'b1;
                  state_in         = S_WIPE;
               end else if (item_ff >= 25'(MAX_ITEMS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{ST_OVERFLOW, 21'd0, 21'd0};
               end else begin
                  item_in  = item_ff + 1'b1;
                  cmd.load = 1'b1;
                  state_in = S_MUL1;
               end
            end
         end
         S_WIPE: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{ST_CLEARED, 21'd0, 21'd0};
               state_in     = S_IDLE;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_SUM1;
         end
         S_SUM1: begin
            cmd.mul_sum = 1'b1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_SUM2;
         end
         S_SUM2: begin
            cmd.mul_sum = 1'b1;
            state_in    = S_HASH;
         end
         S_HASH: begin
            cmd.probe_start = 1'b1;
            state_in        = S_READ;
         end
         S_READ: begin
            cmd.read_slot = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (!sts.slot_valid) begin
               cmd.write_new = 1'b1;
               rsp_in        = '{ST_NEW, item_ff[20:0], 21'd1};
            end else if (sts.key_match) begin
               cmd.write_dup = 1'b1;
               rsp_in        = '{ST_DUP, rd_first, rd_count + 21'd1};
            end else if (sts.probes_done) begin
               rsp_in = '{ST_FULL, 21'd0, 21'd0};
            end else begin
               rsp_valid_in   = 1'b0;
               cmd.probe_next = 1'b1;
               state_in       = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         item_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign item_out  = item_ff[20:0];
endmodule

@@ tb/tb.sv @@
// Self-checking bench for hash_distinct_key_tracker: queued driver, clocked monitor, inline predictor.
// Depends on hdkt_pkg and the tracker RTL; runs a small table so full and overflow cases occur.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hdkt_pkg::*;

   localparam int SLOTS = 64;
   localparam int MAX_CNT = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   req_word_type pending_words[$];
   rsp_word_type expected_rsps[$];
   int           errors = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_request = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   logic         tbl_valid[SLOTS];
   logic [63:0]  tbl_key[SLOTS];
   logic [20:0]  tbl_first[SLOTS];
   logic [20:0]  tbl_count[SLOTS];
   int           item_num = 0;

   hash_distinct_key_tracker #(.TABLE_SLOTS(SLOTS), .MAX_ITEMS(MAX_CNT)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] mix_key(logic [63:0] z);
      z = z ^ (z >> 30);
      z = z * MIX_C1;
      z = z ^ (z >> 27);
      z = z * MIX_C2;
      z = z ^ (z >> 31);
      return z[31:0] ^ z[63:32];
   endfunction

   function automatic rsp_word_type track_key(req_word_type w);
      rsp_word_type r;
      logic [63:0]  hv;
      logic [63:0]  k;
      int           slot;
      r = '0;
      if (w.cmd) begin
         for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
         item_num = 0;
         r.status = ST_CLEARED;
         return r;
      end
      if (item_num >= MAX_CNT) begin
         r.status = ST_OVERFLOW;
         return r;
      end
      item_num++;
      hv = {32'd0, mix_key(w.key_word)};
      for (k = 0; k < SLOTS; k++) begin
         slot = int'((hv + (k * (k + 64'd1)) / 64'd2) % SLOTS);
         if (!tbl_valid[slot]) begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot] = w.key_word;
            tbl_first[slot] = item_num[20:0];
            tbl_count[slot] = 21'd1;
            r.status = ST_NEW;
            r.first_index = item_num[20:0];
            r.occurrences = 21'd1;
            return r;
         end
         if (tbl_key[slot] == w.key_word) begin
            tbl_count[slot] = tbl_count[slot] + 21'd1;
            r.status = ST_DUP;
            r.first_index = tbl_first[slot];
            r.occurrences = tbl_count[slot];
            return r;
         end
      end
      r.status = ST_FULL;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(track_key(req_word));
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= 2000;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected word status=%0d", rsp_word.status);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_word.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.first_index !== e.first_index) begin
               $error("first_index expected %0d actual %0d", e.first_index, rsp_word.first_index);
               errors++;
            end
            if (rsp_word.occurrences !== e.occurrences) begin
               $error("occurrences expected %0d actual %0d", e.occurrences, rsp_word.occurrences);
               errors++;
            end
         end
      end
   end

   task automatic push_word(logic c, logic [63:0] key);
      req_word_type w;
      w.cmd = c;
      w.key_word = key;
      pending_words.push_back(w);
   endtask

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   // Clear, then a run of words: mostly inserts drawn from a small key pool, some random keys, and occasional clears.
   task automatic push_vector(int n);
      logic [63:0] pool[$];
      int          psize;
      int          sel;
      psize = $urandom_range(90, 3);
      for (int i = 0; i < psize; i++) pool.push_back(rand_key());
      push_word(1'b1, rand_key());
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 82) push_word(1'b0, pool[$urandom_range(psize - 1)]);
         else if (sel < 97) push_word(1'b0, rand_key());
         else push_word(1'b1, rand_key());
      end
   endtask

   task automatic run_phase(int idle, int stall, int items, bit pressure);
      int pushed;
      int n;
      send_idle_pct = idle;
      stall_pct = stall;
      if (pressure) hold_request = hold_request + 1;
      pushed = 0;
      while (pushed < items) begin
         if ($urandom_range(9) == 0) begin
            push_vector(MAX_CNT + 10);
            pushed += MAX_CNT + 11;
         end else begin
            n = $urandom_range(100, 10);
            push_vector(n);
            pushed += n + 1;
         end
      end
      while (pending_words.size() > 0) @(posedge clock);
   endtask

   initial begin
      int wait_cycles;
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      push_word(1'b0, 64'd0);
      push_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_word(1'b0, 64'h8000_0000_0000_0000);
      push_word(1'b0, 64'd1);
      push_word(1'b0, 64'd0);
      push_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_word(1'b0, 64'd0);
      push_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      push_word(1'b0, 64'd0);
      push_word(1'b0, 64'd0);
      push_word(1'b1, 64'd0);
      run_phase(0, 0, 350, 1'b0);
      run_phase(58, 0, 330, 1'b0);
      run_phase(0, 58, 330, 1'b0);
      run_phase(36, 36, 330, 1'b0);
      run_phase(0, 0, 330, 1'b1);
      while (req_valid) @(posedge clock);
      wait_cycles = 0;
      while (expected_rsps.size() > 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (3 * SLOTS + 300) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
